// ----- rtl/core/two_anchor_range_to_pose_unit_macros.svh -----
// Assertion macros shared by the two-anchor pose unit.
`ifndef TWO_ANCHOR_RANGE_TO_POSE_UNIT_MACROS_SVH
`define TWO_ANCHOR_RANGE_TO_POSE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TARP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TARP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tarp_pkg.sv -----
// Shared types, constants and helper functions of the two-anchor pose unit.
package tarp_pkg;

  // history and averaging
  localparam int AVG_DEPTH = 8;
  localparam int RANGE_W   = 16;
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W     = RANGE_W + SLOT_W;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  // datapath widths
  localparam int DIV_W     = 50;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int DEN_W     = 17;
  localparam int MA_W      = 38;
  localparam int MB_W      = 18;
  localparam int MP_W      = MA_W + MB_W;
  localparam int X_W       = 36;
  localparam int Y_W       = 17;
  localparam int RAD_W     = 32;
  localparam int RAD_SW    = 34;
  localparam int SQ_STEPS  = 16;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int SQ_REM_W  = SQ_STEPS + 3;
  localparam int OX_W      = 18;
  localparam int CW        = DIV_W + 1;
  localparam int HV_W      = 45;
  localparam int Z_W       = 25;
  localparam int ATAN_W    = 21;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W    = $clog2(CORDIC_STEPS);
  localparam int HEAD_W    = 16;

  localparam logic signed [DIV_W-1:0] X_SQ_LIM = DIV_W'(65536);
  localparam logic signed [CW-1:0]    OX_HI    = CW'(131071);
  localparam logic signed [CW-1:0]    OX_LO    = -CW'(131072);
  localparam logic signed [HV_W-1:0]  HV_LIM   = HV_W'(64'sd1 <<< 40);
  localparam logic signed [Z_W-1:0]   ANG_FULL = Z_W'(9216000);
  localparam logic signed [Z_W-1:0]   ANG_HALF = Z_W'(4608000);
  localparam logic [HEAD_W:0]         HEAD_WRAP = (HEAD_W+1)'(36000);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  localparam logic [15:0]        ANCHOR_RST = 16'd1000;
  localparam logic [11:0]        TAG_RST    = 12'd500;
  localparam logic signed [12:0] OFFSET_RST = 13'sd0;

  typedef struct packed {
    logic [15:0]        anchor_spacing;
    logic [11:0]        tag_spacing;
    logic signed [12:0] center_offset;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] dev_left;
    logic [RANGE_W-1:0] dev_right;
    logic [RANGE_W-1:0] rem_left;
    logic [RANGE_W-1:0] rem_right;
  } avg_word_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DEN_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [DIV_W-1:0] quotient;
  } div_rsp_t;

  // arctangent of 2^-i in 1/25600 degree
  function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] a;
    case (idx)
      5'd0:  a = 21'd1152000;
      5'd1:  a = 21'd680065;
      5'd2:  a = 21'd359328;
      5'd3:  a = 21'd182400;
      5'd4:  a = 21'd91554;
      5'd5:  a = 21'd45822;
      5'd6:  a = 21'd22916;
      5'd7:  a = 21'd11459;
      5'd8:  a = 21'd5730;
      5'd9:  a = 21'd2865;
      5'd10: a = 21'd1432;
      5'd11: a = 21'd716;
      5'd12: a = 21'd358;
      5'd13: a = 21'd179;
      5'd14: a = 21'd90;
      5'd15: a = 21'd45;
      5'd16: a = 21'd22;
      5'd17: a = 21'd11;
      5'd18: a = 21'd6;
      5'd19: a = 21'd3;
      default: a = '0;
    endcase
    return a;
  endfunction

  // clamp a wide coordinate to the 18-bit output range
  function automatic logic signed [OX_W-1:0] sat_coord(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    if (v > OX_HI) c = OX_HI;
    else if (v < OX_LO) c = OX_LO;
    else c = v;
    return c[OX_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tarp_front.sv -----
// Front end: range histories, running sums and averages per accepted word.
module tarp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tarp_pkg::RANGE_W-1:0]  in_device_left_range,
  input  logic [tarp_pkg::RANGE_W-1:0]  in_device_right_range,
  input  logic                          in_device_pair_ok,
  input  logic [tarp_pkg::RANGE_W-1:0]  in_remote_left_range,
  input  logic [tarp_pkg::RANGE_W-1:0]  in_remote_right_range,
  input  logic                          in_remote_pair_ok,
  input  logic                          fifo_full,
  output logic                          push,
  output tarp_pkg::avg_word_t           push_data
);

  logic [tarp_pkg::RANGE_W-1:0] dl_hist_r [tarp_pkg::AVG_DEPTH];
  logic [tarp_pkg::RANGE_W-1:0] dr_hist_r [tarp_pkg::AVG_DEPTH];
  logic [tarp_pkg::RANGE_W-1:0] rl_hist_r [tarp_pkg::AVG_DEPTH];
  logic [tarp_pkg::RANGE_W-1:0] rr_hist_r [tarp_pkg::AVG_DEPTH];
  logic [tarp_pkg::SLOT_W-1:0]  dev_slot_r, dev_slot_nxt;
  logic [tarp_pkg::SLOT_W-1:0]  rem_slot_r, rem_slot_nxt;
  logic [tarp_pkg::SUM_W-1:0]   dl_sum_r, dl_sum_nxt;
  logic [tarp_pkg::SUM_W-1:0]   dr_sum_r, dr_sum_nxt;
  logic [tarp_pkg::SUM_W-1:0]   rl_sum_r, rl_sum_nxt;
  logic [tarp_pkg::SUM_W-1:0]   rr_sum_r, rr_sum_nxt;
  logic                         accept, dev_wr, rem_wr;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;
  assign dev_wr   = accept && in_device_pair_ok;
  assign rem_wr   = accept && in_remote_pair_ok;
  assign push     = accept;

  // swap the oldest entry out of each running sum
  always_comb begin
    dl_sum_nxt   = dl_sum_r;
    dr_sum_nxt   = dr_sum_r;
    rl_sum_nxt   = rl_sum_r;
    rr_sum_nxt   = rr_sum_r;
    dev_slot_nxt = dev_slot_r;
    rem_slot_nxt = rem_slot_r;
    if (dev_wr) begin
      dl_sum_nxt = dl_sum_r - tarp_pkg::SUM_W'(dl_hist_r[dev_slot_r])
                 + tarp_pkg::SUM_W'(in_device_left_range);
      dr_sum_nxt = dr_sum_r - tarp_pkg::SUM_W'(dr_hist_r[dev_slot_r])
                 + tarp_pkg::SUM_W'(in_device_right_range);
      dev_slot_nxt = (dev_slot_r == tarp_pkg::SLOT_W'(tarp_pkg::AVG_DEPTH - 1)) ?
                     '0 : dev_slot_r + 1'b1;
    end
    if (rem_wr) begin
      rl_sum_nxt = rl_sum_r - tarp_pkg::SUM_W'(rl_hist_r[rem_slot_r])
                 + tarp_pkg::SUM_W'(in_remote_left_range);
      rr_sum_nxt = rr_sum_r - tarp_pkg::SUM_W'(rr_hist_r[rem_slot_r])
                 + tarp_pkg::SUM_W'(in_remote_right_range);
      rem_slot_nxt = (rem_slot_r == tarp_pkg::SLOT_W'(tarp_pkg::AVG_DEPTH - 1)) ?
                     '0 : rem_slot_r + 1'b1;
    end
  end

  // truncating averages of the updated histories
  assign push_data.dev_left  = tarp_pkg::RANGE_W'(dl_sum_nxt / tarp_pkg::AVG_DEPTH);
  assign push_data.dev_right = tarp_pkg::RANGE_W'(dr_sum_nxt / tarp_pkg::AVG_DEPTH);
  assign push_data.rem_left  = tarp_pkg::RANGE_W'(rl_sum_nxt / tarp_pkg::AVG_DEPTH);
  assign push_data.rem_right = tarp_pkg::RANGE_W'(rr_sum_nxt / tarp_pkg::AVG_DEPTH);

  // hold histories, slots and sums; clear them at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tarp_pkg::AVG_DEPTH; i++) begin
        dl_hist_r[i] <= '0;
        dr_hist_r[i] <= '0;
        rl_hist_r[i] <= '0;
        rr_hist_r[i] <= '0;
      end
      dev_slot_r <= '0;
      rem_slot_r <= '0;
      dl_sum_r   <= '0;
      dr_sum_r   <= '0;
      rl_sum_r   <= '0;
      rr_sum_r   <= '0;
    end else begin
      if (dev_wr) begin
        dl_hist_r[dev_slot_r] <= in_device_left_range;
        dr_hist_r[dev_slot_r] <= in_device_right_range;
      end
      if (rem_wr) begin
        rl_hist_r[rem_slot_r] <= in_remote_left_range;
        rr_hist_r[rem_slot_r] <= in_remote_right_range;
      end
      dev_slot_r <= dev_slot_nxt;
      rem_slot_r <= rem_slot_nxt;
      dl_sum_r   <= dl_sum_nxt;
      dr_sum_r   <= dr_sum_nxt;
      rl_sum_r   <= rl_sum_nxt;
      rr_sum_r   <= rr_sum_nxt;
    end
  end

endmodule

// ----- rtl/core/tarp_fifo.sv -----
// Two-entry queue of averaged range words between front and back.
module tarp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tarp_pkg::avg_word_t push_data,
  input  logic                pop,
  output tarp_pkg::avg_word_t head,
  output logic                empty,
  output logic                full
);

  tarp_pkg::avg_word_t             mem_r [tarp_pkg::FIFO_DEPTH];
  logic [tarp_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [tarp_pkg::FIFO_CNT_W-1:0] count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == tarp_pkg::FIFO_CNT_W'(tarp_pkg::FIFO_DEPTH));

  // store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- rtl/core/tarp_div.sv -----
// Bit-serial signed-by-unsigned divider, truncating toward zero.
module tarp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tarp_pkg::div_req_t req,
  output tarp_pkg::div_rsp_t rsp
);

  logic [tarp_pkg::DIV_W-1:0]     quo_r, mag;
  logic [tarp_pkg::DEN_W-1:0]     rem_r, den_r, rem_nxt;
  logic [tarp_pkg::DEN_W:0]       trial;
  logic                           fit, neg_r, busy_r, done_r;
  logic [tarp_pkg::DIV_CNT_W-1:0] cnt_r;

  assign mag   = req.dividend[tarp_pkg::DIV_W-1] ? -req.dividend : req.dividend;
  assign trial = {rem_r, quo_r[tarp_pkg::DIV_W-1]};
  assign fit   = (trial >= {1'b0, den_r});
  assign rem_nxt = fit ? tarp_pkg::DEN_W'(trial - {1'b0, den_r})
                       : trial[tarp_pkg::DEN_W-1:0];

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -signed'(quo_r) : signed'(quo_r);

  // shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= mag;
        rem_r  <= '0;
        den_r  <= req.divisor;
        neg_r  <= req.dividend[tarp_pkg::DIV_W-1];
        cnt_r  <= tarp_pkg::DIV_CNT_W'(tarp_pkg::DIV_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[tarp_pkg::DIV_W-2:0], fit};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/tarp_back.sv -----
// Back end: trilateration, square root, centre offset and CORDIC heading.
`include "two_anchor_range_to_pose_unit_macros.svh"

module tarp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tarp_pkg::cfg_t                    cfg,
  input  logic                              fifo_empty,
  input  tarp_pkg::avg_word_t               head,
  output logic                              pop,
  output tarp_pkg::div_req_t                div_req,
  input  tarp_pkg::div_rsp_t                div_rsp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tarp_pkg::OX_W-1:0]  out_device_x,
  output logic [tarp_pkg::Y_W-1:0]          out_device_y,
  output logic signed [tarp_pkg::OX_W-1:0]  out_remote_x,
  output logic [tarp_pkg::Y_W-1:0]          out_remote_y,
  output logic signed [tarp_pkg::OX_W-1:0]  out_robot_x,
  output logic signed [tarp_pkg::OX_W-1:0]  out_robot_y,
  output logic [tarp_pkg::HEAD_W-1:0]       out_heading_centideg
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_L, ST_SQ_R, ST_SQ_U, ST_NUM, ST_DIVX, ST_WAITX, ST_SQX, ST_RAD,
    ST_SQRT, ST_CMUL_Y, ST_CDIV_Y, ST_CWAIT_Y, ST_CMUL_X, ST_CDIV_X, ST_CWAIT_X,
    ST_CENTER, ST_HD_INIT, ST_HD_NORM, ST_HD_ROT, ST_HD_FIN, ST_DONE
  } state_t;

  state_t state_r;
  logic   tag_r, out_valid_r, out_free;

  logic signed [tarp_pkg::DIV_W-1:0]  acc_r, qy_r, qx_r;
  logic signed [tarp_pkg::RAD_SW-1:0] ll_r, rad;
  logic signed [tarp_pkg::MP_W-1:0]   mp_r;
  logic signed [tarp_pkg::MA_W-1:0]   ma;
  logic signed [tarp_pkg::MB_W-1:0]   mb;
  logic signed [tarp_pkg::X_W-1:0]    xd_r, xr_r, xsel;
  logic [tarp_pkg::Y_W-1:0]           yd_r, yr_r;
  logic signed [tarp_pkg::OX_W-1:0]   cx_r, cy_r;
  logic [tarp_pkg::RANGE_W-1:0]       cur_l, cur_r, u_eff;
  logic [11:0]                        t_eff;

  logic [tarp_pkg::RAD_W-1:0]         sq_rad_r;
  logic [tarp_pkg::SQ_REM_W-1:0]      sq_rem_r, sq_cand, sq_trial;
  logic [tarp_pkg::SQ_STEPS-1:0]      sq_root_r, sq_root_nxt;
  logic [tarp_pkg::SQ_CNT_W-1:0]      sq_cnt_r;
  logic                               sq_fit;

  logic signed [tarp_pkg::HV_W-1:0]   hx_r, hy_r, hx_init, hy_init, hdx, hdy;
  logic signed [tarp_pkg::Z_W-1:0]    hz_r, atan_z, nz, fz, fr;
  logic [tarp_pkg::STEP_W-1:0]        step_r;
  logic [tarp_pkg::HEAD_W:0]          hd;
  logic [tarp_pkg::HEAD_W-1:0]        heading_r;
  logic                               in_lim;

  logic signed [tarp_pkg::Y_W:0]      dy, den;
  logic signed [tarp_pkg::X_W:0]      dx, num, sx, sx_half;
  logic [tarp_pkg::Y_W:0]             sy;
  logic signed [tarp_pkg::CW-1:0]     cx_full, cy_full;
  state_t                             after_tag;

  assign cur_l = tag_r ? head.rem_left  : head.dev_left;
  assign cur_r = tag_r ? head.rem_right : head.dev_right;
  assign u_eff = (cfg.anchor_spacing == '0) ? 16'd1 : cfg.anchor_spacing;
  assign t_eff = (cfg.tag_spacing == '0) ? 12'd1 : cfg.tag_spacing;
  assign xsel  = tag_r ? xr_r : xd_r;
  assign after_tag = tag_r ? ST_CMUL_Y : ST_SQ_L;

  // tag differences and half sums
  assign dy  = {1'b0, yr_r} - {1'b0, yd_r};
  assign den = {1'b0, yd_r} - {1'b0, yr_r};
  assign dx  = {xr_r[tarp_pkg::X_W-1], xr_r} - {xd_r[tarp_pkg::X_W-1], xd_r};
  assign num = {xd_r[tarp_pkg::X_W-1], xd_r} - {xr_r[tarp_pkg::X_W-1], xr_r};
  assign sx  = {xd_r[tarp_pkg::X_W-1], xd_r} + {xr_r[tarp_pkg::X_W-1], xr_r};
  assign sx_half = (sx + signed'({{tarp_pkg::X_W{1'b0}}, sx[tarp_pkg::X_W]})) >>> 1;
  assign sy  = ({1'b0, yd_r} + {1'b0, yr_r}) >> 1;
  assign cx_full = {{(tarp_pkg::CW-tarp_pkg::X_W-1){sx_half[tarp_pkg::X_W]}}, sx_half}
                 - {qy_r[tarp_pkg::DIV_W-1], qy_r};
  assign cy_full = {{(tarp_pkg::CW-tarp_pkg::Y_W-1){1'b0}}, sy}
                 + {qx_r[tarp_pkg::DIV_W-1], qx_r};

  // radicand of the current tag
  assign rad = ll_r - mp_r[tarp_pkg::RAD_SW-1:0];

  // one square-root digit
  assign sq_cand  = {sq_rem_r[tarp_pkg::SQ_REM_W-3:0], sq_rad_r[tarp_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_fit   = (sq_cand >= sq_trial);
  assign sq_root_nxt = {sq_root_r[tarp_pkg::SQ_STEPS-2:0], sq_fit};

  // heading vector setup and one CORDIC rotation
  assign hx_init = {{(tarp_pkg::HV_W-tarp_pkg::Y_W-1){den[tarp_pkg::Y_W]}}, den};
  assign hy_init = {{(tarp_pkg::HV_W-tarp_pkg::X_W-1){num[tarp_pkg::X_W]}}, num};
  assign in_lim  = (hx_r < tarp_pkg::HV_LIM) && (hx_r > -tarp_pkg::HV_LIM) &&
                   (hy_r < tarp_pkg::HV_LIM) && (hy_r > -tarp_pkg::HV_LIM);
  assign hdx     = hy_r >>> step_r;
  assign hdy     = hx_r >>> step_r;
  assign atan_z  = {{(tarp_pkg::Z_W-tarp_pkg::ATAN_W){1'b0}}, tarp_pkg::atan_step(step_r)};
  assign nz      = -hz_r;
  assign fz      = (nz < 0) ? nz + tarp_pkg::ANG_FULL : nz;
  assign fr      = fz + tarp_pkg::Z_W'(128);
  assign hd      = fr[tarp_pkg::HEAD_W+8:8];

  // drive the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_SQ_L: begin
        ma = {{(tarp_pkg::MA_W-tarp_pkg::RANGE_W){1'b0}}, cur_l};
        mb = {{(tarp_pkg::MB_W-tarp_pkg::RANGE_W){1'b0}}, cur_l};
      end
      ST_SQ_R: begin
        ma = {{(tarp_pkg::MA_W-tarp_pkg::RANGE_W){1'b0}}, cur_r};
        mb = {{(tarp_pkg::MB_W-tarp_pkg::RANGE_W){1'b0}}, cur_r};
      end
      ST_SQ_U: begin
        ma = {{(tarp_pkg::MA_W-tarp_pkg::RANGE_W){1'b0}}, u_eff};
        mb = {{(tarp_pkg::MB_W-tarp_pkg::RANGE_W){1'b0}}, u_eff};
      end
      ST_SQX: begin
        ma = {{(tarp_pkg::MA_W-tarp_pkg::X_W){xsel[tarp_pkg::X_W-1]}}, xsel};
        mb = xsel[tarp_pkg::MB_W-1:0];
      end
      ST_CMUL_Y: begin
        ma = {{(tarp_pkg::MA_W-tarp_pkg::Y_W-1){dy[tarp_pkg::Y_W]}}, dy};
        mb = {{(tarp_pkg::MB_W-13){cfg.center_offset[12]}}, cfg.center_offset};
      end
      ST_CMUL_X: begin
        ma = {{(tarp_pkg::MA_W-tarp_pkg::X_W-1){dx[tarp_pkg::X_W]}}, dx};
        mb = {{(tarp_pkg::MB_W-13){cfg.center_offset[12]}}, cfg.center_offset};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // start the divider on trilateration and centre terms
  assign div_req.start    = (state_r == ST_DIVX) || (state_r == ST_CDIV_Y) ||
                            (state_r == ST_CDIV_X);
  assign div_req.dividend = (state_r == ST_DIVX) ? acc_r : mp_r[tarp_pkg::DIV_W-1:0];
  assign div_req.divisor  = (state_r == ST_DIVX) ? {u_eff, 1'b0}
                          : {{(tarp_pkg::DEN_W-12){1'b0}}, t_eff};

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_DONE) && out_free;
  assign out_valid = out_valid_r;

  // register the product every cycle
  always_ff @(posedge clk) begin
    mp_r <= ma * mb;
  end

  // sequencer with its working and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !pop) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          tag_r <= 1'b0;
          if (!fifo_empty) state_r <= ST_SQ_L;
        end
        ST_SQ_L: state_r <= ST_SQ_R;
        ST_SQ_R: begin
          ll_r    <= mp_r[tarp_pkg::RAD_SW-1:0];
          acc_r   <= mp_r[tarp_pkg::DIV_W-1:0];
          state_r <= ST_SQ_U;
        end
        ST_SQ_U: begin
          acc_r   <= acc_r - mp_r[tarp_pkg::DIV_W-1:0];
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          acc_r   <= acc_r + mp_r[tarp_pkg::DIV_W-1:0];
          state_r <= ST_DIVX;
        end
        ST_DIVX: state_r <= ST_WAITX;
        ST_WAITX: begin
          if (div_rsp.done) begin
            if (tag_r) xr_r <= div_rsp.quotient[tarp_pkg::X_W-1:0];
            else       xd_r <= div_rsp.quotient[tarp_pkg::X_W-1:0];
            if ((div_rsp.quotient < tarp_pkg::X_SQ_LIM) &&
                (div_rsp.quotient > -tarp_pkg::X_SQ_LIM)) begin
              state_r <= ST_SQX;
            end else begin
              // X beyond the left range: radicand negative
              if (tag_r) yr_r <= '0;
              else       yd_r <= '0;
              tag_r   <= ~tag_r;
              state_r <= after_tag;
            end
          end
        end
        ST_SQX: state_r <= ST_RAD;
        ST_RAD: begin
          if (rad < 0) begin
            if (tag_r) yr_r <= '0;
            else       yd_r <= '0;
            tag_r   <= ~tag_r;
            state_r <= after_tag;
          end else begin
            sq_rad_r  <= rad[tarp_pkg::RAD_W-1:0];
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= tarp_pkg::SQ_CNT_W'(tarp_pkg::SQ_STEPS - 1);
            state_r   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sq_rem_r  <= sq_fit ? sq_cand - sq_trial : sq_cand;
          sq_root_r <= sq_root_nxt;
          sq_rad_r  <= sq_rad_r << 2;
          sq_cnt_r  <= sq_cnt_r - 1'b1;
          if (sq_cnt_r == '0) begin
            if (tag_r) yr_r <= {1'b0, sq_root_nxt};
            else       yd_r <= {1'b0, sq_root_nxt};
            tag_r   <= ~tag_r;
            state_r <= after_tag;
          end
        end
        ST_CMUL_Y: state_r <= ST_CDIV_Y;
        ST_CDIV_Y: state_r <= ST_CWAIT_Y;
        ST_CWAIT_Y: begin
          if (div_rsp.done) begin
            qy_r    <= div_rsp.quotient;
            state_r <= ST_CMUL_X;
          end
        end
        ST_CMUL_X: state_r <= ST_CDIV_X;
        ST_CDIV_X: state_r <= ST_CWAIT_X;
        ST_CWAIT_X: begin
          if (div_rsp.done) begin
            qx_r    <= div_rsp.quotient;
            state_r <= ST_CENTER;
          end
        end
        ST_CENTER: begin
          cx_r    <= tarp_pkg::sat_coord(cx_full);
          cy_r    <= tarp_pkg::sat_coord(cy_full);
          state_r <= ST_HD_INIT;
        end
        ST_HD_INIT: begin
          if ((den == 0) && (num == 0)) begin
            // coincident tags
            heading_r <= '0;
            state_r   <= ST_DONE;
          end else begin
            if (den < 0) begin
              hx_r <= -hx_init;
              hy_r <= -hy_init;
              hz_r <= tarp_pkg::ANG_HALF;
            end else begin
              hx_r <= hx_init;
              hy_r <= hy_init;
              hz_r <= '0;
            end
            state_r <= ST_HD_NORM;
          end
        end
        ST_HD_NORM: begin
          if (in_lim) begin
            hx_r <= hx_r <<< 1;
            hy_r <= hy_r <<< 1;
          end else begin
            step_r  <= '0;
            state_r <= ST_HD_ROT;
          end
        end
        ST_HD_ROT: begin
          if (!hy_r[tarp_pkg::HV_W-1]) begin
            hx_r <= hx_r + hdx;
            hy_r <= hy_r - hdy;
            hz_r <= hz_r + atan_z;
          end else begin
            hx_r <= hx_r - hdx;
            hy_r <= hy_r + hdy;
            hz_r <= hz_r - atan_z;
          end
          step_r <= step_r + 1'b1;
          if (step_r == tarp_pkg::STEP_W'(tarp_pkg::CORDIC_STEPS - 1)) state_r <= ST_HD_FIN;
        end
        ST_HD_FIN: begin
          heading_r <= (hd >= tarp_pkg::HEAD_WRAP) ? '0 : hd[tarp_pkg::HEAD_W-1:0];
          state_r   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_device_x         <= tarp_pkg::sat_coord(
              {{(tarp_pkg::CW-tarp_pkg::X_W){xd_r[tarp_pkg::X_W-1]}}, xd_r});
            out_remote_x         <= tarp_pkg::sat_coord(
              {{(tarp_pkg::CW-tarp_pkg::X_W){xr_r[tarp_pkg::X_W-1]}}, xr_r});
            out_device_y         <= yd_r;
            out_remote_y         <= yr_r;
            out_robot_x          <= cx_r;
            out_robot_y          <= cy_r;
            out_heading_centideg <= heading_r;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `TARP_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `TARP_ASSERT_IMP(a_pop_has_word, pop, !fifo_empty, "pop from an empty queue")
  `TARP_ASSERT_NXT(a_pop_loads_out, pop, out_valid_r, "result not presented after pop")

endmodule

// ----- rtl/core/two_anchor_range_to_pose_unit.sv -----
// Two-anchor pose unit: config registers, front end, queue, divider and back end.
//
// Usage: one word on the in_ channel is one ranging round of two tags. A pair
// flagged ok enters its 8-deep range histories; the averages then feed
// two-anchor trilateration of both tags, the robot centre and the heading.
// Each accepted word gives one result word on the out_ channel, in order.
// Configuration writes (cfg_index, cfg_data) are taken at any cycle; index 0
// anchor spacing, 1 tag spacing, 2 centre offset, other indexes are dropped.
// Each word runs four 50-step divisions on the bit-serial divider, a 16-step
// square root per tag with a non-negative radicand, the heading normalize and
// 20 CORDIC steps; the back end finishes one word before it takes the next.
// The front end averages in the accept cycle; the two-word queue keeps the word
// under work and takes one more round while the back end works or the receiver
// stalls. A stalled out_ready holds the result register; the back end waits at
// the end of its sequence. Reset clears the histories, slots, queue and result
// valid at once and restores the register defaults.
module two_anchor_range_to_pose_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [15:0]                        in_device_left_range,
  input  logic [15:0]                        in_device_right_range,
  input  logic                               in_device_pair_ok,
  input  logic [15:0]                        in_remote_left_range,
  input  logic [15:0]                        in_remote_right_range,
  input  logic                               in_remote_pair_ok,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tarp_pkg::OX_W-1:0]   out_device_x,
  output logic [tarp_pkg::Y_W-1:0]           out_device_y,
  output logic signed [tarp_pkg::OX_W-1:0]   out_remote_x,
  output logic [tarp_pkg::Y_W-1:0]           out_remote_y,
  output logic signed [tarp_pkg::OX_W-1:0]   out_robot_x,
  output logic signed [tarp_pkg::OX_W-1:0]   out_robot_y,
  output logic [tarp_pkg::HEAD_W-1:0]        out_heading_centideg,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tarp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  tarp_pkg::cfg_t      cfg_r;
  tarp_pkg::avg_word_t push_data, head;
  tarp_pkg::div_req_t  div_req;
  tarp_pkg::div_rsp_t  div_rsp;
  logic                push, pop, fifo_empty, fifo_full;

  assign cfg_ready = 1'b1;

  // decode configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.anchor_spacing <= tarp_pkg::ANCHOR_RST;
      cfg_r.tag_spacing    <= tarp_pkg::TAG_RST;
      cfg_r.center_offset  <= tarp_pkg::OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tarp_pkg::CFG_ANCHOR: cfg_r.anchor_spacing <= cfg_data;
        tarp_pkg::CFG_TAG:    cfg_r.tag_spacing    <= cfg_data[11:0];
        tarp_pkg::CFG_OFFSET: cfg_r.center_offset  <= signed'(cfg_data[12:0]);
        default: ;
      endcase
    end
  end

  tarp_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_device_left_range  (in_device_left_range),
    .in_device_right_range (in_device_right_range),
    .in_device_pair_ok     (in_device_pair_ok),
    .in_remote_left_range  (in_remote_left_range),
    .in_remote_right_range (in_remote_right_range),
    .in_remote_pair_ok     (in_remote_pair_ok),
    .fifo_full             (fifo_full),
    .push                  (push),
    .push_data             (push_data)
  );

  tarp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  tarp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tarp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .fifo_empty           (fifo_empty),
    .head                 (head),
    .pop                  (pop),
    .div_req              (div_req),
    .div_rsp              (div_rsp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_device_x         (out_device_x),
    .out_device_y         (out_device_y),
    .out_remote_x         (out_remote_x),
    .out_remote_y         (out_remote_y),
    .out_robot_x          (out_robot_x),
    .out_robot_y          (out_robot_y),
    .out_heading_centideg (out_heading_centideg)
  );

endmodule

// ----- sim/tb_two_anchor_range_to_pose_unit.sv -----
// Testbench for the two-anchor range-to-pose unit: random and directed rounds, scored.
`timescale 1ns / 1ps

module tb_two_anchor_range_to_pose_unit;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 1500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASES         = 5;
  localparam int ROUNDS_PER_PHASE = 380;
  localparam logic [tarp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [15:0] dev_l;
    logic [15:0] dev_r;
    logic        dev_ok;
    logic [15:0] rem_l;
    logic [15:0] rem_r;
    logic        rem_ok;
  } round_t;

  typedef struct {
    logic [17:0] dev_x;
    logic [16:0] dev_y;
    logic [17:0] rem_x;
    logic [16:0] rem_y;
    logic [17:0] ctr_x;
    logic [17:0] ctr_y;
    logic [15:0] head;
  } pose_t;

  // Pose predictor and scoreboard: keeps its own histories and registers.
  class pose_scoreboard;
    logic [15:0] dl_hist[tarp_pkg::AVG_DEPTH];
    logic [15:0] dr_hist[tarp_pkg::AVG_DEPTH];
    logic [15:0] rl_hist[tarp_pkg::AVG_DEPTH];
    logic [15:0] rr_hist[tarp_pkg::AVG_DEPTH];
    int          dev_slot;
    int          rem_slot;
    longint      anchor_sp;
    longint      tag_sp;
    longint      ofs;
    pose_t       expected_poses[$];
    int          errors;
    int          checked;

    function void clear();
      foreach (dl_hist[i]) begin
        dl_hist[i] = '0; dr_hist[i] = '0; rl_hist[i] = '0; rr_hist[i] = '0;
      end
      dev_slot = 0;
      rem_slot = 0;
      anchor_sp = 1000;
      tag_sp = 500;
      ofs = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [tarp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        tarp_pkg::CFG_ANCHOR: anchor_sp = longint'(data);
        tarp_pkg::CFG_TAG:    tag_sp = longint'(data[11:0]);
        tarp_pkg::CFG_OFFSET: ofs = longint'($signed(data[12:0]));
        default: ;
      endcase
    endfunction

    function longint mean(logic [15:0] h[tarp_pkg::AVG_DEPTH]);
      longint s;
      s = 0;
      foreach (h[i]) s += longint'(h[i]);
      return s / tarp_pkg::AVG_DEPTH;
    endfunction

    function longint int_sqrt(longint val);
      bit [63:0] v, r, b;
      v = val; r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void locate(longint l, longint r, longint u, output longint x, output longint y);
      longint rad;
      x = (l * l - r * r + u * u) / (2 * u);
      rad = l * l - x * x;
      y = (rad < 0) ? 0 : int_sqrt(rad);
    endfunction

    // CORDIC vectoring in 1/25600 degree, then map to centidegrees
    function logic [15:0] bearing(longint num, longint den);
      longint atan_lut[20] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                               11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
      longint x, y, z, dx, dy, f, lim;
      x = den; y = num; z = 0; lim = longint'(1) << 40;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
        x = -x; y = -y; z = 4608000;
      end
      while (x < lim && x > -lim && y < lim && y > -lim) begin
        x *= 2; y *= 2;
      end
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_lut[i];
        end else begin
          x -= dx; y += dy; z -= atan_lut[i];
        end
      end
      f = (-z) % 64'sd9216000;
      if (f < 0) f += 9216000;
      f = (f + 128) / 256;
      if (f >= 36000) f = 0;
      return f[15:0];
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Note an accepted round: update histories and queue the expected pose.
    function void note_round(round_t rd);
      longint u, t, xd, yd, xr, yr, cx, cy;
      pose_t p;
      u = anchor_sp ? anchor_sp : 1;
      t = tag_sp ? tag_sp : 1;
      if (rd.dev_ok) begin
        dl_hist[dev_slot] = rd.dev_l;
        dr_hist[dev_slot] = rd.dev_r;
        dev_slot = (dev_slot + 1) % tarp_pkg::AVG_DEPTH;
      end
      if (rd.rem_ok) begin
        rl_hist[rem_slot] = rd.rem_l;
        rr_hist[rem_slot] = rd.rem_r;
        rem_slot = (rem_slot + 1) % tarp_pkg::AVG_DEPTH;
      end
      locate(mean(dl_hist), mean(dr_hist), u, xd, yd);
      locate(mean(rl_hist), mean(rr_hist), u, xr, yr);
      cx = (xd + xr) / 2 - (ofs * (yr - yd)) / t;
      cy = (yd + yr) / 2 + (ofs * (xr - xd)) / t;
      p.dev_x = 18'(clip(xd, -131072, 131071));
      p.dev_y = 17'(clip(yd, 0, 131071));
      p.rem_x = 18'(clip(xr, -131072, 131071));
      p.rem_y = 17'(clip(yr, 0, 131071));
      p.ctr_x = 18'(clip(cx, -131072, 131071));
      p.ctr_y = 18'(clip(cy, -131072, 131071));
      p.head  = bearing(xd - xr, yd - yr);
      expected_poses.push_back(p);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
      errors++;
    endtask

    // Check one result word against the oldest expected pose.
    task check_pose(pose_t got);
      pose_t e;
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected result word", 0, 0);
        return;
      end
      e = expected_poses.pop_front();
      if (got.dev_x !== e.dev_x)
        report_mismatch("device_x", $signed(got.dev_x), $signed(e.dev_x));
      if (got.dev_y !== e.dev_y) report_mismatch("device_y", got.dev_y, e.dev_y);
      if (got.rem_x !== e.rem_x)
        report_mismatch("remote_x", $signed(got.rem_x), $signed(e.rem_x));
      if (got.rem_y !== e.rem_y) report_mismatch("remote_y", got.rem_y, e.rem_y);
      if (got.ctr_x !== e.ctr_x)
        report_mismatch("robot_x", $signed(got.ctr_x), $signed(e.ctr_x));
      if (got.ctr_y !== e.ctr_y)
        report_mismatch("robot_y", $signed(got.ctr_y), $signed(e.ctr_y));
      if (got.head !== e.head) report_mismatch("heading", got.head, e.head);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_device_left_range = '0;
  logic [15:0] in_device_right_range = '0;
  logic in_device_pair_ok = 1'b0;
  logic [15:0] in_remote_left_range = '0;
  logic [15:0] in_remote_right_range = '0;
  logic in_remote_pair_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tarp_pkg::OX_W-1:0] out_device_x, out_remote_x, out_robot_x, out_robot_y;
  logic [tarp_pkg::Y_W-1:0] out_device_y, out_remote_y;
  logic [tarp_pkg::HEAD_W-1:0] out_heading_centideg;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tarp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pose_scoreboard sb;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int rounds_sent = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  two_anchor_range_to_pose_unit u_dut (.*);

  always #5 clk = ~clk;

  // Watchdog: end the run after too long without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (rst_n) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_two_anchor_range_to_pose_unit failed");
        $finish;
      end
    end
  end

  // Result monitor: score every accepted result word.
  always @(posedge clk) begin
    pose_t got;
    if (rst_n && out_valid && out_ready) begin
      got.dev_x = out_device_x; got.dev_y = out_device_y;
      got.rem_x = out_remote_x; got.rem_y = out_remote_y;
      got.ctr_x = out_robot_x; got.ctr_y = out_robot_y;
      got.head  = out_heading_centideg;
      sb.check_pose(got);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Write one register; returns in the cycle after the word is taken.
  task write_reg(logic [tarp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one round; hold valid until taken, then optionally idle.
  task send_round(round_t rd);
    int gap;
    in_valid <= 1'b1;
    in_device_left_range  <= rd.dev_l;
    in_device_right_range <= rd.dev_r;
    in_device_pair_ok     <= rd.dev_ok;
    in_remote_left_range  <= rd.rem_l;
    in_remote_right_range <= rd.rem_r;
    in_remote_pair_ok     <= rd.rem_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_round(rd);
    rounds_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every expected pose, then let the pipe settle.
  task wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function round_t mk_round(logic [15:0] dl, logic [15:0] dr, logic dok,
                            logic [15:0] rl, logic [15:0] rr, logic rok);
    round_t rd;
    rd.dev_l = dl; rd.dev_r = dr; rd.dev_ok = dok;
    rd.rem_l = rl; rd.rem_r = rr; rd.rem_ok = rok;
    return rd;
  endfunction

  // Plausible range near a base, clamped to the field.
  function logic [15:0] near(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function round_t rand_round();
    round_t rd;
    int bl, br;
    if ($urandom_range(0, 4) == 0) begin
      // noise: any value in every field
      rd = mk_round(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                    16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    end else begin
      bl = $urandom_range(0, 8000);
      br = $urandom_range(0, 8000);
      rd = mk_round(near(bl, 300), near(br, 300), $urandom_range(0, 7) != 0,
                    near(bl, 600), near(br, 600), $urandom_range(0, 7) != 0);
    end
    return rd;
  endfunction

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, extremes, invalid pairs, coincident tags, negative radicand
    send_round(mk_round(16'd0, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1));
    for (int i = 0; i < 8; i++)
      send_round(mk_round(16'd0, 16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 1'b1));
    for (int i = 0; i < 8; i++)
      send_round(mk_round(16'd1200, 16'd900, 1'b1, 16'd1200, 16'd900, 1'b1));
    send_round(mk_round(16'hFFFF, 16'hFFFF, 1'b0, 16'hAAAA, 16'h5555, 1'b0));
    send_round(mk_round(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
    wait_idle();

    // Extremes of every register, zero spacings and an unused index
    write_reg(tarp_pkg::CFG_ANCHOR, 16'hFFFF);
    write_reg(tarp_pkg::CFG_TAG, 16'h0FFF);
    write_reg(tarp_pkg::CFG_OFFSET, 16'(-4095));
    write_reg(CFG_UNUSED, 16'h1234);
    send_round(mk_round(16'hFFFF, 16'd0, 1'b1, 16'd0, 16'hFFFF, 1'b1));
    send_round(mk_round(16'd40000, 16'd30000, 1'b1, 16'd30000, 16'd40000, 1'b1));
    wait_idle();
    write_reg(tarp_pkg::CFG_ANCHOR, 16'd0);
    write_reg(tarp_pkg::CFG_TAG, 16'd0);
    write_reg(tarp_pkg::CFG_OFFSET, 16'd4095);
    send_round(mk_round(16'd500, 16'd700, 1'b1, 16'd800, 16'd100, 1'b1));
    send_round(mk_round(16'hFFFF, 16'd1, 1'b1, 16'd1, 16'hFFFF, 1'b1));
    wait_idle();

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) no_idle = 1'b1;
      case (ph)
        0: begin
          write_reg(tarp_pkg::CFG_ANCHOR, 16'd1000);
          write_reg(tarp_pkg::CFG_TAG, 16'd500);
          write_reg(tarp_pkg::CFG_OFFSET, 16'd0);
        end
        1: begin
          write_reg(tarp_pkg::CFG_ANCHOR, 16'd1);
          write_reg(tarp_pkg::CFG_TAG, 16'd1);
          write_reg(tarp_pkg::CFG_OFFSET, 16'(-4095));
        end
        default: begin
          write_reg(tarp_pkg::CFG_ANCHOR, 16'($urandom_range(1, 12000)));
          write_reg(tarp_pkg::CFG_TAG, 16'($urandom));
          write_reg(tarp_pkg::CFG_OFFSET, 16'($urandom));
        end
      endcase
      for (int k = 0; k < ROUNDS_PER_PHASE; k++) begin
        if (ph == 2 && k == 20) hold_req = 1'b1;
        send_round(rand_round());
      end
      wait_idle();
    end

    $display("Sent %0d rounds and checked %0d poses over %0d register writes,",
             rounds_sent, sb.checked, cfg_writes);
    $display("including extreme spacings, offsets, invalid pairs and a long output stall.");
    if (sb.errors == 0 && sb.expected_poses.size() == 0)
      $display("tb_two_anchor_range_to_pose_unit passed");
    else
      $display("tb_two_anchor_range_to_pose_unit failed");
    $finish;
  end

endmodule
